>>> rtl/core/sseg_pkg.sv
// Package for the seven-segment message scanner.
// Holds the item and result types, mode codes, glyph tables and divider constants.
// No dependencies.
package sseg_pkg;

	localparam int unsigned DIGIT_COUNT = 8;
	localparam int unsigned MODE_COUNT = 6;
	localparam int unsigned CLOCK_DIGITS = 4;

	localparam logic [2:0] KIND_DONE = 3'd0;
	localparam logic [2:0] KIND_SELECT = 3'd1;
	localparam logic [2:0] KIND_DASHES = 3'd2;
	localparam logic [2:0] KIND_STOP = 3'd3;
	localparam logic [2:0] KIND_MMSS = 3'd4;
	localparam logic [2:0] KIND_MMSS_BLINK = 3'd5;

	localparam logic [7:0] DASH_GLYPH = 8'hfd;
	localparam logic [7:0] POINT_MASK = 8'hfe;
	localparam logic [7:0] BLANK_GLYPH = 8'hff;

	// Reciprocal multipliers, exact for every 16-bit dividend.
	localparam logic [15:0] RECIP_10 = 16'd52429;
	localparam int unsigned SHIFT_10 = 19;
	localparam logic [15:0] RECIP_60 = 16'd34953;
	localparam int unsigned SHIFT_60 = 21;
	localparam logic [16:0] RECIP_600 = 17'd111849;
	localparam int unsigned SHIFT_600 = 26;
	localparam logic [16:0] RECIP_3600 = 17'd74566;
	localparam int unsigned SHIFT_3600 = 28;

	typedef struct packed {
		logic [2:0] kind;
		logic [15:0] seconds;
		logic [3:0] select_value;
	} sseg_item_t;

	typedef struct packed {
		logic [2:0] digit_index;
		logic [7:0] segments;
	} sseg_result_t;

	function automatic logic [7:0] num_glyph(input logic [3:0] value);
		logic [7:0] g;
		case (value)
			4'd0: g = 8'h03;
			4'd1: g = 8'h9f;
			4'd2: g = 8'h25;
			4'd3: g = 8'h0d;
			4'd4: g = 8'h99;
			4'd5: g = 8'h49;
			4'd6: g = 8'h41;
			4'd7: g = 8'h1b;
			4'd8: g = 8'h01;
			4'd9: g = 8'h19;
			4'd10: g = 8'hfe;
			default: g = BLANK_GLYPH;
		endcase
		return g;
	endfunction

	function automatic logic [7:0] select_glyph(input logic [2:0] pos);
		logic [7:0] g;
		case (pos)
			3'd0: g = 8'h49;
			3'd1: g = 8'h61;
			3'd2: g = 8'he3;
			3'd3: g = 8'h61;
			3'd4: g = 8'h63;
			3'd5: g = 8'h73;
			3'd6: g = 8'h03;
			default: g = BLANK_GLYPH;
		endcase
		return g;
	endfunction

	function automatic logic [7:0] done_glyph(input logic [1:0] pos);
		logic [7:0] g;
		case (pos)
			2'd0: g = 8'h85;
			2'd1: g = 8'hc5;
			2'd2: g = 8'hd5;
			default: g = 8'h61;
		endcase
		return g;
	endfunction

	function automatic logic [7:0] stop_glyph(input logic [1:0] pos);
		logic [7:0] g;
		case (pos)
			2'd0: g = 8'h49;
			2'd1: g = 8'h1f;
			2'd2: g = 8'h03;
			default: g = 8'h31;
		endcase
		return g;
	endfunction

endpackage

>>> rtl/core/seven_segment_message_scanner_top.sv
// Top level of the seven-segment message scanner: one input register stage and one result stage.
// Depends on sseg_pkg for the transaction types, mode codes and glyph tables.
//
//   channel   valid          stall          payload
//   input     item_valid     item_stall     item   (sseg_item_t)
//   output    result_valid   result_stall   result (sseg_result_t)
//
// Every input transaction produces exactly one result transaction, registered through the _s1 and then the _s2 stage.
// A new transaction is taken every cycle unless item_stall is high; the per-mode scan position is read and
// advanced at acceptance, and the digit arithmetic runs between the _s1 and _s2 registers.
// Reset clears all scan positions and both stage valid bits.
// A stalled output holds the result, and the input stalls only when both stages are full.
module seven_segment_message_scanner_top
	import sseg_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_stall,
	input  sseg_item_t   item,
	output logic         result_valid,
	input  logic         result_stall,
	output sseg_result_t result
);

	logic [2:0] scan_position_q [MODE_COUNT];

	logic valid_s1;
	logic [2:0] kind_s1;
	logic [15:0] seconds_s1;
	logic [3:0] select_value_s1;
	logic [2:0] pos_s1;

	logic valid_s2;
	sseg_result_t result_s2;

	logic advance_s1;
	logic accept;
	logic kind_ok;
	logic [2:0] pos_raw;
	logic [2:0] pos_msg;
	logic [2:0] pos_next;

	logic [31:0] prod_10;
	logic [31:0] prod_60;
	logic [32:0] prod_600;
	logic [32:0] prod_3600;
	logic [12:0] q10;
	logic [10:0] q60;
	logic [6:0] q600;
	logic [4:0] q3600;
	logic [15:0] rem_sec_ones;
	logic [12:0] rem_sec_tens;
	logic [10:0] rem_min_ones;
	logic [6:0] rem_min_tens;
	logic [3:0] clock_digit;
	logic [1:0] clock_pos;
	sseg_result_t result_d;

	assign advance_s1 = !valid_s2 || !result_stall;
	assign item_stall = valid_s1 && !advance_s1;
	assign accept = item_valid && !item_stall;

	assign kind_ok = (item.kind <= KIND_MMSS_BLINK);
	assign pos_raw = kind_ok ? scan_position_q[item.kind] : 3'd0;

	always_comb begin
		pos_msg = (32'(pos_raw) >= DIGIT_COUNT) ? 3'd0 : pos_raw;
		if (item.kind >= KIND_MMSS) begin
			pos_next = (32'(pos_raw[1:0]) + 32'd1 >= CLOCK_DIGITS)
				? 3'd0 : {1'b0, pos_raw[1:0] + 2'd1};
		end else begin
			pos_next = (32'(pos_msg) + 32'd1 >= DIGIT_COUNT) ? 3'd0 : pos_msg + 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MODE_COUNT; i++) begin
				scan_position_q[i] <= 3'd0;
			end
		end else if (accept && kind_ok) begin
			scan_position_q[item.kind] <= pos_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance_s1 || !valid_s1) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= item.kind;
			seconds_s1 <= item.seconds;
			select_value_s1 <= item.select_value;
			pos_s1 <= (item.kind >= KIND_MMSS) ? {1'b0, pos_raw[1:0]} : pos_msg;
		end
	end

	assign prod_10 = 32'(seconds_s1) * 32'(RECIP_10);
	assign prod_60 = 32'(seconds_s1) * 32'(RECIP_60);
	assign prod_600 = 33'(seconds_s1) * 33'(RECIP_600);
	assign prod_3600 = 33'(seconds_s1) * 33'(RECIP_3600);
	assign q10 = prod_10[SHIFT_10 +: 13];
	assign q60 = prod_60[SHIFT_60 +: 11];
	assign q600 = prod_600[SHIFT_600 +: 7];
	assign q3600 = prod_3600[SHIFT_3600 +: 5];

	assign rem_sec_ones = seconds_s1 - 16'(q10) * 16'd10;
	assign rem_sec_tens = q10 - 13'(q60) * 13'd6;
	assign rem_min_ones = q60 - 11'(q600) * 11'd10;
	assign rem_min_tens = q600 - 7'(q3600) * 7'd6;

	assign clock_pos = pos_s1[1:0];

	always_comb begin
		case (clock_pos)
			2'd0: clock_digit = rem_sec_ones[3:0];
			2'd1: clock_digit = rem_sec_tens[3:0];
			2'd2: clock_digit = rem_min_ones[3:0];
			default: clock_digit = rem_min_tens[3:0];
		endcase
	end

	always_comb begin
		result_d.digit_index = pos_s1;
		result_d.segments = BLANK_GLYPH;
		case (kind_s1)
			KIND_DONE: begin
				result_d.segments = done_glyph(pos_s1[1:0]);
			end
			KIND_SELECT: begin
				if (32'(pos_s1) < DIGIT_COUNT - 1) begin
					result_d.segments = select_glyph(pos_s1);
				end else begin
					result_d.segments = num_glyph(select_value_s1);
				end
			end
			KIND_DASHES: begin
				result_d.segments = DASH_GLYPH;
			end
			KIND_STOP: begin
				result_d.segments = stop_glyph(pos_s1[1:0]);
			end
			KIND_MMSS, KIND_MMSS_BLINK: begin
				result_d.digit_index = 3'd3 - pos_s1;
				result_d.segments = num_glyph(clock_digit);
				if (kind_s1 == KIND_MMSS_BLINK && clock_pos == 2'd1 && seconds_s1[0]) begin
					result_d.segments = num_glyph(clock_digit) & POINT_MASK;
				end
			end
			default: begin
				result_d.digit_index = 3'd0;
				result_d.segments = BLANK_GLYPH;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && valid_s1) begin
			result_s2 <= result_d;
		end
	end

	assign result_valid = valid_s2;
	assign result = result_s2;

endmodule

>>> bench/tb_top.sv
// Self-checking bench for seven_segment_message_scanner_top: directed table, then random scan ticks.
// Predicts untyped scan ticks from its own per-mode scan positions and glyph tables.
// Depends on sseg_pkg for the transaction types, mode codes and blank, dash and point constants.
`timescale 1ns / 1ps

module tb_top;
	import sseg_pkg::*;

	localparam int DIRECTED_ROWS = 24;
	localparam int RANDOM_ITEMS = 2000;
	localparam int CYCLE_LIMIT = 200000;
	localparam int REPORT_LIMIT = 10;
	localparam int DRAIN_CYCLES = 8;

	localparam logic [7:0] NUMERAL_SEGS [11] = '{
		8'h03, 8'h9f, 8'h25, 8'h0d, 8'h99, 8'h49, 8'h41, 8'h1b, 8'h01, 8'h19, 8'hfe
	};
	localparam logic [7:0] SELECT_SEGS [7] = '{8'h49, 8'h61, 8'he3, 8'h61, 8'h63, 8'h73, 8'h03};
	localparam logic [7:0] DONE_SEGS [4] = '{8'h85, 8'hc5, 8'hd5, 8'h61};
	localparam logic [7:0] STOP_SEGS [4] = '{8'h49, 8'h1f, 8'h03, 8'h31};

	typedef struct packed {
		logic typed;
		sseg_item_t item;
		sseg_result_t want;
	} tick_row_t;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	sseg_item_t item;
	logic result_valid;
	logic result_stall = 1'b0;
	sseg_result_t result;

	logic [2:0] scan_pos [MODE_COUNT];
	sseg_result_t expected_digits [$];
	logic typed_flag;
	sseg_result_t typed_want;
	tick_row_t directed_rows [DIRECTED_ROWS];

	int burst_left = 0;
	int fault_count = 0;
	int checked_count = 0;
	int cycle_count = 0;
	int stall_run = 0;
	int stall_phase = 0;
	logic stall_level = 1'b0;

	seven_segment_message_scanner_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic sseg_result_t next_display_digit(input sseg_item_t it);
		sseg_result_t r;
		logic [2:0] p;
		logic [1:0] q;
		int unsigned s;
		r.digit_index = 3'd0;
		r.segments = BLANK_GLYPH;
		s = it.seconds;
		if (it.kind > KIND_MMSS_BLINK)
			return r;
		p = scan_pos[it.kind];
		if (it.kind <= KIND_STOP) begin
			r.digit_index = p;
			case (it.kind)
				KIND_DONE: r.segments = DONE_SEGS[p[1:0]];
				KIND_SELECT: begin
					if (int'(p) < DIGIT_COUNT - 1)
						r.segments = SELECT_SEGS[p];
					else if (it.select_value <= 4'd10)
						r.segments = NUMERAL_SEGS[it.select_value];
				end
				KIND_DASHES: r.segments = DASH_GLYPH;
				default: r.segments = STOP_SEGS[p[1:0]];
			endcase
			scan_pos[it.kind] = (int'(p) + 1 >= DIGIT_COUNT) ? 3'd0 : p + 3'd1;
		end else begin
			q = p[1:0];
			r.digit_index = 3'd3 - {1'b0, q};
			case (q)
				2'd0: r.segments = NUMERAL_SEGS[s % 10];
				2'd1: begin
					r.segments = NUMERAL_SEGS[(s / 10) % 6];
					if (it.kind == KIND_MMSS_BLINK && s[0])
						r.segments = r.segments & POINT_MASK;
				end
				2'd2: r.segments = NUMERAL_SEGS[(s / 60) % 10];
				default: r.segments = NUMERAL_SEGS[(s / 600) % 6];
			endcase
			scan_pos[it.kind] = (q == 2'd3) ? 3'd0 : {1'b0, q + 2'd1};
		end
		return r;
	endfunction

	function automatic tick_row_t make_row(input logic typed, input logic [2:0] kind,
			input logic [15:0] secs, input logic [3:0] sel, input logic [2:0] idx,
			input logic [7:0] segs);
		tick_row_t row;
		row.typed = typed;
		row.item.kind = kind;
		row.item.seconds = secs;
		row.item.select_value = sel;
		row.want.digit_index = idx;
		row.want.segments = segs;
		return row;
	endfunction

	// Called just after a falling edge; returns just after the falling edge that follows acceptance.
	task automatic issue_tick(input tick_row_t row);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
			repeat (gap) begin
				item_valid = 1'b0;
				item = sseg_item_t'(23'($urandom));
				@(negedge clk);
			end
		end
		item = row.item;
		typed_flag = row.typed;
		typed_want = row.want;
		item_valid = 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		burst_left--;
		@(negedge clk);
	endtask

	always @(posedge clk) begin : scoreboard
		sseg_result_t predicted;
		sseg_result_t want;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				predicted = next_display_digit(item);
				expected_digits.push_back(typed_flag ? typed_want : predicted);
			end
			if (result_valid && !result_stall) begin
				checked_count++;
				if (expected_digits.size() == 0) begin
					if (fault_count < REPORT_LIMIT)
						$display("Unexpected result transaction: digit %0d segments %02h",
							result.digit_index, result.segments);
					fault_count++;
				end else begin
					want = expected_digits.pop_front();
					if (result.digit_index !== want.digit_index
							|| result.segments !== want.segments) begin
						if (fault_count < REPORT_LIMIT)
							$display("Mismatch: expected digit %0d segments %02h, got digit %0d segments %02h",
								want.digit_index, want.segments,
								result.digit_index, result.segments);
						fault_count++;
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		stall_phase++;
		if (stall_run == 0) begin
			stall_level = $urandom_range(0, 1);
			stall_run = stall_level ? $urandom_range(1, 6) : $urandom_range(1, 10);
		end
		stall_run--;
		result_stall = (stall_phase % 512 < 128) ? 1'b0 : stall_level;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.",
				cycle_count, expected_digits.size());
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin : stimulus
		tick_row_t row;
		int unsigned roll;
		logic [2:0] run_kind;
		int run_len;
		int sent;
		for (int m = 0; m < MODE_COUNT; m++)
			scan_pos[m] = 3'd0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		typed_flag = 1'b0;
		typed_want = '0;
		sent = 0;

		directed_rows[0] = make_row(1'b1, KIND_DONE, 16'd0, 4'd0, 3'd0, 8'h85);
		directed_rows[1] = make_row(1'b1, KIND_MMSS, 16'd0, 4'd0, 3'd3, 8'h03);
		directed_rows[2] = make_row(1'b0, KIND_MMSS_BLINK, 16'hffff, 4'hf, 3'd0, 8'h00);
		directed_rows[3] = make_row(1'b0, KIND_MMSS_BLINK, 16'hffff, 4'hf, 3'd0, 8'h00);
		directed_rows[4] = make_row(1'b1, 3'd6, 16'd0, 4'd0, 3'd0, BLANK_GLYPH);
		directed_rows[5] = make_row(1'b1, 3'd7, 16'hffff, 4'hf, 3'd0, BLANK_GLYPH);
		directed_rows[6] = make_row(1'b1, KIND_DASHES, 16'hffff, 4'hf, 3'd0, DASH_GLYPH);
		directed_rows[7] = make_row(1'b1, KIND_STOP, 16'd0, 4'd0, 3'd0, 8'h49);
		for (int k = 0; k < 7; k++)
			directed_rows[8 + k] = make_row(1'b0, KIND_SELECT, 16'(k), 4'(k), 3'd0, 8'h00);
		directed_rows[15] = make_row(1'b1, KIND_SELECT, 16'd0, 4'd10, 3'd7, POINT_MASK);
		for (int k = 0; k < 7; k++)
			directed_rows[16 + k] = make_row(1'b0, KIND_SELECT, 16'hffff, 4'(11 + k % 5),
				3'd0, 8'h00);
		directed_rows[23] = make_row(1'b1, KIND_SELECT, 16'hffff, 4'd15, 3'd7, BLANK_GLYPH);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[r])
			issue_tick(directed_rows[r]);

		while (sent < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 19);
			run_kind = (roll < 18) ? 3'(roll / 3) : 3'(6 + (roll & 1));
			run_len = $urandom_range(1, 12);
			for (int j = 0; j < run_len; j++) begin
				row.typed = 1'b0;
				row.want = '0;
				row.item.kind = run_kind;
				if ($urandom_range(0, 3) == 0) begin
					case ($urandom_range(0, 5))
						0: row.item.seconds = 16'd0;
						1: row.item.seconds = 16'hffff;
						2: row.item.seconds = 16'd599;
						3: row.item.seconds = 16'd600;
						4: row.item.seconds = 16'd3599;
						default: row.item.seconds = 16'd59;
					endcase
				end else begin
					row.item.seconds = 16'($urandom_range(0, 65535));
				end
				row.item.select_value = ($urandom_range(0, 3) == 0)
					? 4'($urandom_range(11, 15)) : 4'($urandom_range(0, 10));
				issue_tick(row);
				sent++;
				if (sent == RANDOM_ITEMS / 2) begin
					item_valid = 1'b0;
					while (expected_digits.size() != 0)
						@(negedge clk);
					burst_left = 0;
				end
			end
		end

		item_valid = 1'b0;
		while (expected_digits.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d directed and %0d random scan ticks over all eight kind codes.",
			DIRECTED_ROWS, sent);
		$display("Compared %0d result transactions; %0d faults, %0d still outstanding.",
			checked_count, fault_count, expected_digits.size());
		if (fault_count == 0 && expected_digits.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
